>>> hdl/pcp_pkg.sv
// Shared types, widths and constants for the phase current Clarke/Park block.
// Holds the quarter-wave sine table, built at elaboration. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pcp_pkg;

  // Field widths of the channels and the gain register.
  localparam int COUNT_W = 13;
  localparam int ANGLE_W = 16;
  localparam int GAIN_W  = 16;
  localparam int OUT_W   = 16;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd26806;

  // Internal datapath widths.
  localparam int CUR_W   = 29;  // count * gain, 2^-24 A
  localparam int SUM_W   = 31;  // a + 2b
  localparam int BPROD_W = 48;  // (a + 2b) * 1/sqrt3 in Q0.16
  localparam int BETA_W  = 30;  // beta, 2^-24 A
  localparam int TRIG_W  = 17;  // signed Q1.15 sine/cosine
  localparam int PARK_W  = 48;  // rotated products and sums, 2^-39 A
  localparam int SHR_W   = PARK_W - 27;

  localparam int PIPE_DEPTH = 7;

  localparam logic signed [TRIG_W-1:0] INV_SQRT3_Q16 = 17'sd37837;

  // Sine table: entry k = sin(k * pi/2 / N) in Q1.15, N = 2^SINE_TABLE_BITS.
  localparam int SINE_TABLE_BITS = 10;
  localparam int QUARTER_N       = 1 << SINE_TABLE_BITS;
  localparam int ROM_AW          = SINE_TABLE_BITS + 1;
  localparam int ROM_W           = 15;
  localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;

  typedef logic [ROM_W-1:0] sine_rom_t [QUARTER_N+1];

  // Integer Taylor series in Q30 up to x^15; each term is truncated.
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t       rom;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    longint          r;
    int unsigned     k;
    for (k = 0; k <= QUARTER_N; k++) begin
      x    = (64'(k) * PI_HALF_Q30) >> SINE_TABLE_BITS;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      // Each term is the previous one times x^2 over (2n)(2n+1), signs alternating.
      term = ((term * x2) >> 30) / 64'd6;
      sum  = sum - longint'(term);
      term = ((term * x2) >> 30) / 64'd20;
      sum  = sum + longint'(term);
      term = ((term * x2) >> 30) / 64'd42;
      sum  = sum - longint'(term);
      term = ((term * x2) >> 30) / 64'd72;
      sum  = sum + longint'(term);
      term = ((term * x2) >> 30) / 64'd110;
      sum  = sum - longint'(term);
      term = ((term * x2) >> 30) / 64'd156;
      sum  = sum + longint'(term);
      term = ((term * x2) >> 30) / 64'd210;
      sum  = sum - longint'(term);
      r = (sum > 0) ? ((sum + 64'sd16384) >>> 15) : 64'sd0;
      if (r > 64'sd32767) begin
        r = 64'sd32767;
      end
      rom[k] = ROM_W'(r);
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

`default_nettype wire

>>> hdl/pcp_if.sv
// Valid/ready channel interfaces for the sample input and the d/q result.
// Depends on pcp_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface pcp_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [pcp_pkg::COUNT_W-1:0]    phase_a_count;
  logic signed [pcp_pkg::COUNT_W-1:0]    phase_b_count;
  logic        [pcp_pkg::ANGLE_W-1:0]    electrical_angle;

  modport source (output valid, phase_a_count, phase_b_count, electrical_angle,
                  input ready);
  modport sink (input valid, phase_a_count, phase_b_count, electrical_angle,
                output ready);
endinterface

interface pcp_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [pcp_pkg::OUT_W-1:0]   current_d;
  logic signed [pcp_pkg::OUT_W-1:0]   current_q;

  modport source (output valid, current_d, current_q, input ready);
  modport sink (input valid, current_d, current_q, output ready);
endinterface

`default_nettype wire

>>> hdl/phase_current_clarke_park.sv
// Top level: gain scaling, two-current Clarke and Park transforms, saturation.
// Depends on pcp_pkg and the channel interfaces in pcp_if.sv.
//
//   channel   dir   payload                                          handshake
//   in_ch     in    phase_a_count, phase_b_count, electrical_angle   valid/ready
//   out_ch    out   current_d, current_q                             valid/ready
//   cfg_*     in    current_gain (cfg_wdata)                         cfg_we
//
// One item per cycle is accepted unless the output stalls; multiplier stages
// serve the gain, 1/sqrt3 and the Park rotation.
// Reset empties the pipeline and loads the gain with its default.
// When the output item is not taken, the whole pipeline holds; nothing is lost.
// The sine table is a constant ROM read through registered stages.
`timescale 1ns / 1ps
`default_nettype none

module phase_current_clarke_park (
  input  wire                          clk,
  input  wire                          rst_n,
  pcp_in_if.sink                       in_ch,
  pcp_out_if.source                    out_ch,
  input  wire                          cfg_we,
  input  wire [pcp_pkg::GAIN_W-1:0]    cfg_wdata
);

  localparam int D = pcp_pkg::PIPE_DEPTH;

  logic [pcp_pkg::GAIN_W-1:0] gain_r;
  logic [D-1:0]               valid_r;
  logic [D-1:0]               valid_nxt;
  logic                       en;

  // Stage 1: gain scaling and table addresses.
  logic signed [pcp_pkg::CUR_W:0]   ia_prod;
  logic signed [pcp_pkg::CUR_W:0]   ib_prod;
  logic signed [pcp_pkg::CUR_W-1:0] a1_r, b1_r;
  logic [1:0]                       sin_quad, cos_quad;
  logic [pcp_pkg::SINE_TABLE_BITS-1:0] idx;
  logic [pcp_pkg::ROM_AW-1:0]       sin_addr_nxt, cos_addr_nxt;
  logic [pcp_pkg::ROM_AW-1:0]       sin_addr1_r, cos_addr1_r;
  logic                             sin_neg1_r, cos_neg1_r;

  // Stage 2: a + 2b and table reads.
  logic signed [pcp_pkg::SUM_W-1:0] sum2_r;
  logic signed [pcp_pkg::CUR_W-1:0] a2_r;
  logic [pcp_pkg::ROM_W-1:0]        sin_mag2_r, cos_mag2_r;
  logic                             sin_neg2_r, cos_neg2_r;

  // Stage 3: scale by 1/sqrt3, apply quadrant signs.
  logic signed [pcp_pkg::BPROD_W-1:0] bprod3_r;
  logic signed [pcp_pkg::CUR_W-1:0]   a3_r;
  logic signed [pcp_pkg::TRIG_W-1:0]  sin_pos, cos_pos;
  logic signed [pcp_pkg::TRIG_W-1:0]  st3_r, ct3_r;

  // Stage 4: round beta.
  logic signed [pcp_pkg::BPROD_W-1:0] brnd;
  logic signed [pcp_pkg::BETA_W-1:0]  beta4_r;
  logic signed [pcp_pkg::CUR_W-1:0]   a4_r;
  logic signed [pcp_pkg::TRIG_W-1:0]  st4_r, ct4_r;

  // Stage 5: the four rotation products.
  logic signed [pcp_pkg::PARK_W-1:0] acos5_r, bsin5_r, bcos5_r, asin5_r;

  // Stage 6: d and q sums.
  logic signed [pcp_pkg::PARK_W-1:0] d6_r, q6_r;

  // Stage 7: rounding shift and saturation into the output register.
  logic signed [pcp_pkg::PARK_W-1:0] d_rnd, q_rnd;
  logic signed [pcp_pkg::SHR_W-1:0]  d_sh, q_sh;
  logic signed [pcp_pkg::OUT_W-1:0]  d_sat, q_sat;
  logic signed [pcp_pkg::OUT_W-1:0]  d7_r, q7_r;

  function automatic logic signed [pcp_pkg::OUT_W-1:0] sat16(
    input logic signed [pcp_pkg::SHR_W-1:0] v
  );
    logic signed [pcp_pkg::OUT_W-1:0] res;
    if (v > pcp_pkg::SHR_W'(32767)) begin
      res = 16'sh7FFF;
    end else if (v < -(pcp_pkg::SHR_W'(32768))) begin
      res = 16'sh8000;
    end else begin
      res = v[pcp_pkg::OUT_W-1:0];
    end
    return res;
  endfunction

  // The pipeline moves as a whole whenever the last stage is empty or taken.
  assign en           = !valid_r[D-1] || out_ch.ready;
  assign in_ch.ready  = en;
  assign valid_nxt    = {valid_r[D-2:0], in_ch.valid};

  assign out_ch.valid     = valid_r[D-1];
  assign out_ch.current_d = d7_r;
  assign out_ch.current_q = q7_r;

  assign ia_prod = in_ch.phase_a_count * $signed({1'b0, gain_r});
  assign ib_prod = in_ch.phase_b_count * $signed({1'b0, gain_r});

  // cos(t) = sin(t + quarter turn): same index, next quadrant.
  assign idx      = in_ch.electrical_angle[13 -: pcp_pkg::SINE_TABLE_BITS];
  assign sin_quad = in_ch.electrical_angle[15:14];
  assign cos_quad = sin_quad + 2'd1;
  assign sin_addr_nxt = sin_quad[0]
      ? pcp_pkg::ROM_AW'(pcp_pkg::QUARTER_N) - {1'b0, idx} : {1'b0, idx};
  assign cos_addr_nxt = cos_quad[0]
      ? pcp_pkg::ROM_AW'(pcp_pkg::QUARTER_N) - {1'b0, idx} : {1'b0, idx};

  assign sin_pos = $signed({2'b00, sin_mag2_r});
  assign cos_pos = $signed({2'b00, cos_mag2_r});

  assign brnd  = bprod3_r + pcp_pkg::BPROD_W'(32768);
  assign d_rnd = d6_r + pcp_pkg::PARK_W'(1 << 26);
  assign q_rnd = q6_r + pcp_pkg::PARK_W'(1 << 26);
  assign d_sh  = d_rnd[pcp_pkg::PARK_W-1:27];
  assign q_sh  = q_rnd[pcp_pkg::PARK_W-1:27];
  assign d_sat = sat16(d_sh);
  assign q_sat = sat16(q_sh);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r  <= pcp_pkg::GAIN_RESET;
      valid_r <= '0;
    end else begin
      if (cfg_we) begin
        gain_r <= cfg_wdata;
      end
      if (en) begin
        valid_r <= valid_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1_r        <= ia_prod[pcp_pkg::CUR_W-1:0];
      b1_r        <= ib_prod[pcp_pkg::CUR_W-1:0];
      sin_addr1_r <= sin_addr_nxt;
      cos_addr1_r <= cos_addr_nxt;
      sin_neg1_r  <= sin_quad[1];
      cos_neg1_r  <= cos_quad[1];

      sum2_r     <= pcp_pkg::SUM_W'(a1_r) + (pcp_pkg::SUM_W'(b1_r) <<< 1);
      a2_r       <= a1_r;
      sin_mag2_r <= pcp_pkg::SINE_ROM[sin_addr1_r];
      cos_mag2_r <= pcp_pkg::SINE_ROM[cos_addr1_r];
      sin_neg2_r <= sin_neg1_r;
      cos_neg2_r <= cos_neg1_r;

      bprod3_r <= sum2_r * pcp_pkg::INV_SQRT3_Q16;
      a3_r     <= a2_r;
      st3_r    <= sin_neg2_r ? -sin_pos : sin_pos;
      ct3_r    <= cos_neg2_r ? -cos_pos : cos_pos;

      beta4_r <= brnd[16 +: pcp_pkg::BETA_W];
      a4_r    <= a3_r;
      st4_r   <= st3_r;
      ct4_r   <= ct3_r;

      acos5_r <= pcp_pkg::PARK_W'(a4_r) * pcp_pkg::PARK_W'(ct4_r);
      bsin5_r <= pcp_pkg::PARK_W'(beta4_r) * pcp_pkg::PARK_W'(st4_r);
      bcos5_r <= pcp_pkg::PARK_W'(beta4_r) * pcp_pkg::PARK_W'(ct4_r);
      asin5_r <= pcp_pkg::PARK_W'(a4_r) * pcp_pkg::PARK_W'(st4_r);

      d6_r <= acos5_r + bsin5_r;
      q6_r <= bcos5_r - asin5_r;

      d7_r <= d_sat;
      q7_r <= q_sat;
    end
  end

  // A stalled pipeline keeps every stage's occupancy.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(valid_r))
    else $error("pipeline occupancy changed while stalled");

  // An advancing pipeline shifts occupancy by exactly one stage.
  a_shift: assert property (@(posedge clk) disable iff (!rst_n)
    en |=> valid_r == {$past(valid_r[D-2:0]), $past(in_ch.valid)})
    else $error("pipeline occupancy did not shift by one stage");

  // A stalled result keeps its value until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(d7_r) && $stable(q7_r))
    else $error("held result changed while stalled");

  a_cfg: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> gain_r == $past(cfg_wdata))
    else $error("gain register did not take the written value");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> valid_r == '0)
    else $error("pipeline not empty after reset");

endmodule

`default_nettype wire

>>> test/pcp_dq_checker.sv
// Checker for the phase current Clarke/Park block: predicts current_d and current_q
// for each accepted sample and compares them with the result channel.
// Depends on pcp_pkg and the channel interfaces in pcp_if.sv.
`timescale 1ns / 1ps

module pcp_dq_checker (
  input  wire                       clk,
  input  wire                       rst_n,
  pcp_in_if                         in_ch,
  pcp_out_if                        out_ch,
  input  wire                       cfg_we,
  input  wire [pcp_pkg::GAIN_W-1:0] cfg_wdata,
  output int                        fail_count,
  output int                        pending_count,
  output int                        checked_count
);

  localparam longint unsigned HALF_PI_Q30     = 64'd1686629713;
  localparam longint          RECIP_SQRT3_Q16 = 64'sd37837;

  typedef struct packed {
    logic signed [pcp_pkg::OUT_W-1:0] d;
    logic signed [pcp_pkg::OUT_W-1:0] q;
  } dq_pair_t;

  logic [15:0]                quarter_sine [0:pcp_pkg::QUARTER_N];
  logic [pcp_pkg::GAIN_W-1:0] gain_setting = pcp_pkg::GAIN_RESET;
  dq_pair_t                   dq_expected [$];

  longint unsigned   ts_x;
  longint unsigned   ts_x2;
  longint unsigned   ts_term;
  longint            ts_acc;
  longint            ts_val;

  // Quarter-wave sine in Q1.15 from a truncated Taylor series in Q30.
  initial begin
    for (int k = 0; k <= pcp_pkg::QUARTER_N; k++) begin
      ts_x    = (64'(k) * HALF_PI_Q30) >> pcp_pkg::SINE_TABLE_BITS;
      ts_x2   = (ts_x * ts_x) >> 30;
      ts_term = ts_x;
      ts_acc  = longint'(ts_x);
      for (int n = 1; n <= 7; n++) begin
        ts_term = ((ts_term * ts_x2) >> 30) / 64'(2 * n * (2 * n + 1));
        if (n % 2 == 1) begin
          ts_acc = ts_acc - longint'(ts_term);
        end else begin
          ts_acc = ts_acc + longint'(ts_term);
        end
      end
      ts_val = (ts_acc > 0) ? (ts_acc + 16384) / 32768 : 0;
      if (ts_val > 32767) begin
        ts_val = 32767;
      end
      quarter_sine[k] = 16'(ts_val);
    end
  end

  // Rounds half toward plus infinity; the arithmetic shift floors.
  function automatic longint round_half_up(input longint x, input int k);
    return (x + (64'sd1 <<< (k - 1))) >>> k;
  endfunction

  function automatic logic signed [pcp_pkg::OUT_W-1:0] clamp16(input longint v);
    if (v > 32767) begin
      return 16'sh7FFF;
    end else if (v < -32768) begin
      return 16'sh8000;
    end
    return pcp_pkg::OUT_W'(v);
  endfunction

  function automatic longint sine_q15(input logic [pcp_pkg::ANGLE_W-1:0] ang);
    int     idx;
    longint v;
    idx = int'(ang[13:0]) >> (14 - pcp_pkg::SINE_TABLE_BITS);
    // Odd quadrants read the table backward; the upper half turn negates.
    v = ang[14] ? longint'(quarter_sine[pcp_pkg::QUARTER_N - idx])
                : longint'(quarter_sine[idx]);
    return ang[15] ? -v : v;
  endfunction

  function automatic dq_pair_t predict_dq(input logic signed [pcp_pkg::COUNT_W-1:0] a,
                                          input logic signed [pcp_pkg::COUNT_W-1:0] b,
                                          input logic [pcp_pkg::ANGLE_W-1:0]        ang,
                                          input logic [pcp_pkg::GAIN_W-1:0]         gain);
    longint   ia;
    longint   ib;
    longint   beta;
    longint   s;
    longint   c;
    longint   d;
    longint   q;
    dq_pair_t r;
    ia   = longint'(a) * longint'(gain);
    ib   = longint'(b) * longint'(gain);
    beta = round_half_up((ia + 2 * ib) * RECIP_SQRT3_Q16, 16);
    s    = sine_q15(ang);
    c    = sine_q15(16'(ang + 16'd16384));
    d    = ia * c + beta * s;
    q    = beta * c - ia * s;
    r.d  = clamp16(round_half_up(d, 27));
    r.q  = clamp16(round_half_up(q, 27));
    return r;
  endfunction

  always @(posedge clk) begin : monitor
    dq_pair_t want;
    int       errs;
    if (!rst_n) begin
      gain_setting = pcp_pkg::GAIN_RESET;
      dq_expected.delete();
      fail_count    <= 0;
      pending_count <= 0;
      checked_count <= 0;
    end else begin
      errs = 0;
      if (cfg_we) begin
        gain_setting = cfg_wdata;
      end
      if (in_ch.valid && in_ch.ready) begin
        dq_expected.push_back(predict_dq(in_ch.phase_a_count, in_ch.phase_b_count,
                                         in_ch.electrical_angle, gain_setting));
      end
      if (out_ch.valid && out_ch.ready) begin
        if (dq_expected.size() == 0) begin
          $error("result item with no sample pending: current_d %0d, current_q %0d",
                 out_ch.current_d, out_ch.current_q);
          errs = 1;
        end else begin
          want = dq_expected.pop_front();
          if (out_ch.current_d !== want.d) begin
            $error("current_d mismatch: expected %0d, actual %0d", want.d, out_ch.current_d);
            errs++;
          end
          if (out_ch.current_q !== want.q) begin
            $error("current_q mismatch: expected %0d, actual %0d", want.q, out_ch.current_q);
            errs++;
          end
          checked_count <= checked_count + 1;
        end
      end
      fail_count    <= fail_count + errs;
      pending_count <= dq_expected.size();
    end
  end

endmodule

>>> test/phase_current_clarke_park_test.sv
// Testbench top for phase_current_clarke_park: clock, reset, gain writes, sample
// stimulus and result-side stalls. Depends on pcp_pkg, pcp_if.sv and pcp_dq_checker.
`timescale 1ns / 1ps

module phase_current_clarke_park_test;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASES         = 7;
  localparam int PHASE_ITEMS    = 55;
  localparam int DIRECTED_N     = 18;

  logic                       clk = 1'b0;
  logic                       rst_n;
  logic                       cfg_we;
  logic [pcp_pkg::GAIN_W-1:0] cfg_wdata;
  logic                       idle_on;
  int                         quiet_cycles = 0;
  int                         stall_left = 0;
  int                         samples_sent;
  int                         gains_used;
  int                         fail_count;
  int                         pending_count;
  int                         checked_count;

  // Corner samples: full-scale counts of both signs and quadrant edges of the angle.
  int dir_a   [DIRECTED_N] = '{0, 4095, -4096, 4095, -4096, 4095, 0, -4096, 0,
                               1, -1, 4095, -4096, 2048, 100, -1, 4095, -4096};
  int dir_b   [DIRECTED_N] = '{0, 4095, -4096, -4096, 4095, 0, 4095, 0, -4096,
                               -1, 1, 4095, -4096, -2048, 200, -1, -4096, 4095};
  int dir_ang [DIRECTED_N] = '{0, 0, 0, 16384, 32768, 49152, 65535, 16383, 8192,
                               15, 16, 24576, 40960, 57344, 1, 32767, 65520, 49151};

  pcp_in_if  in_ch ();
  pcp_out_if out_ch ();

  phase_current_clarke_park uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  pcp_dq_checker dq_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .fail_count    (fail_count),
    .pending_count (pending_count),
    .checked_count (checked_count)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Result side: random stall bursts while idling is enabled.
  always @(posedge clk) begin
    if (!rst_n) begin
      stall_left   <= 0;
      out_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left   <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left   <= $urandom_range(0, 15);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic signed [pcp_pkg::COUNT_W-1:0] random_count();
    case ($urandom_range(0, 9))
      0:       return 13'sh1000;
      1:       return 13'sh0FFF;
      2:       return 13'sh1FFF;
      default: return pcp_pkg::COUNT_W'($urandom_range(0, 8191));
    endcase
  endfunction

  function automatic logic [pcp_pkg::ANGLE_W-1:0] random_angle();
    case ($urandom_range(0, 7))
      0:       return pcp_pkg::ANGLE_W'($urandom_range(0, 3) << 14);
      1:       return 16'hFFFF;
      default: return pcp_pkg::ANGLE_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // Valid stays high between back-to-back items; it only drops for a gap or a drain.
  task automatic send_sample(input logic signed [pcp_pkg::COUNT_W-1:0] a,
                             input logic signed [pcp_pkg::COUNT_W-1:0] b,
                             input logic [pcp_pkg::ANGLE_W-1:0]        ang);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_ch.valid            <= 1'b1;
    in_ch.phase_a_count    <= a;
    in_ch.phase_b_count    <= b;
    in_ch.electrical_angle <= ang;
    do @(posedge clk); while (!in_ch.ready);
    samples_sent++;
  endtask

  // The pending count is registered, so the loop waits on the clock before it first reads it.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
  endtask

  task automatic write_gain(input logic [pcp_pkg::GAIN_W-1:0] g);
    cfg_we    <= 1'b1;
    cfg_wdata <= g;
    @(posedge clk);
    cfg_we    <= 1'b0;
    gains_used++;
  endtask

  initial begin
    logic [pcp_pkg::GAIN_W-1:0] g;
    rst_n                  = 1'b0;
    cfg_we                 = 1'b0;
    cfg_wdata              = '0;
    idle_on                = 1'b1;
    in_ch.valid            = 1'b0;
    in_ch.phase_a_count    = '0;
    in_ch.phase_b_count    = '0;
    in_ch.electrical_angle = '0;
    samples_sent           = 0;
    gains_used             = 1;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The first pass runs with the gain left at its reset value.
    for (int i = 0; i < DIRECTED_N; i++) begin
      send_sample(pcp_pkg::COUNT_W'(dir_a[i]), pcp_pkg::COUNT_W'(dir_b[i]),
                  pcp_pkg::ANGLE_W'(dir_ang[i]));
    end
    drain_results();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       g = 16'hFFFF;
        1:       g = 16'h0000;
        2:       g = 16'h0001;
        4:       g = pcp_pkg::GAIN_RESET;
        default: g = pcp_pkg::GAIN_W'($urandom_range(0, 65535));
      endcase
      idle_on <= (p != 2) && (p != PHASES - 1);
      write_gain(g);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        send_sample(random_count(), random_count(), random_angle());
      end
      drain_results();
    end

    repeat (pcp_pkg::PIPE_DEPTH + 4) @(posedge clk);
    $display("Sent %0d samples and checked %0d d/q results across %0d gain settings,",
             samples_sent, checked_count, gains_used);
    $display("including zero, unity, full-scale and reset gain with saturating outputs.");
    if (fail_count == 0 && pending_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
